// ===== hdl/ibd_pkg.sv =====
// ----------------------------------------------------------------------------
// ibd_pkg
// Shared types, constants and helpers for the integer to base digits block.
// ----------------------------------------------------------------------------
package ibd_pkg;

  // width of the converted value
  localparam int VALUE_WIDTH = 32;
  // digit counter holds 0 .. VALUE_WIDTH
  localparam int CNT_W       = $clog2(VALUE_WIDTH + 1);
  // stack index and bit counter address 0 .. VALUE_WIDTH-1
  localparam int IDX_W       = $clog2(VALUE_WIDTH);

  localparam logic [7:0] CHAR_MINUS   = 8'h2D;
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_ALPHA   = 8'h41;
  localparam logic [4:0] DEFAULT_BASE = 5'd10;
  localparam logic [7:0] MIN_BASE     = 8'd2;
  localparam logic [7:0] MAX_BASE     = 8'd16;

  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0] value;
    logic        [7:0]             radix;
  } in_item_t;

  typedef struct packed {
    logic [7:0] character;
    logic       last;
  } out_item_t;

  // divider request and response
  typedef struct packed {
    logic                   start;
    logic [VALUE_WIDTH-1:0] dividend;
    logic [4:0]             divisor;
  } div_req_t;

  typedef struct packed {
    logic                   done;
    logic [VALUE_WIDTH-1:0] quotient;
    logic [3:0]             remainder;
  } div_rsp_t;

  // digit stack control
  typedef struct packed {
    logic       push;
    logic       pop;
    logic [3:0] digit;
  } stk_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_SIGN,
    ST_DIGITS,
    ST_ZERO
  } state_e;

  // ascii code of one digit value
  function automatic logic [7:0] digit_char(input logic [3:0] d);
    logic [7:0] c;
    if (d < 4'd10) begin
      c = CHAR_ZERO + {4'd0, d};
    end else begin
      c = CHAR_ALPHA + {4'd0, d - 4'd10};
    end
    return c;
  endfunction

endpackage

// ===== hdl/ibd_divider.sv =====
// ----------------------------------------------------------------------------
// ibd_divider
// Bit-serial restoring divider: one quotient bit per cycle by a small base.
// ----------------------------------------------------------------------------
module ibd_divider (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ibd_pkg::div_req_t req_i,
  output ibd_pkg::div_rsp_t rsp_o
);
  import ibd_pkg::*;

  logic                   busy_q, busy_d;
  logic                   done_q, done_d;
  logic [IDX_W-1:0]       cnt_q, cnt_d;
  logic [VALUE_WIDTH-1:0] quo_q, quo_d;
  logic [3:0]             rem_q, rem_d;
  logic [4:0]             dvs_q, dvs_d;
  logic [4:0]             trial;
  logic [4:0]             diff;
  logic                   fits;

  // one trial subtraction per cycle
  always_comb begin
    trial = {rem_q, quo_q[VALUE_WIDTH-1]};
    fits  = trial >= dvs_q;
    diff  = trial - dvs_q;
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = req_i.dividend;
      rem_d  = '0;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      quo_d = {quo_q[VALUE_WIDTH-2:0], fits};
      rem_d = fits ? diff[3:0] : trial[3:0];
      cnt_d = cnt_q + IDX_W'(1);
      if (cnt_q == IDX_W'(VALUE_WIDTH - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = quo_q;
  assign rsp_o.remainder = rem_q;

endmodule

// ===== hdl/ibd_stack.sv =====
// ----------------------------------------------------------------------------
// ibd_stack
// Digit stack: remainders pushed least significant first, popped in reverse.
// ----------------------------------------------------------------------------
module ibd_stack (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  ibd_pkg::stk_ctl_t       ctl_i,
  output logic [ibd_pkg::CNT_W-1:0] count_o,
  output logic [3:0]              top_o
);
  import ibd_pkg::*;

  logic [3:0]       entry_q [VALUE_WIDTH];
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] count_m1;

  assign count_m1 = count_q - CNT_W'(1);

  // fill level
  always_comb begin
    count_d = count_q;
    if (ctl_i.push) begin
      count_d = count_q + CNT_W'(1);
    end else if (ctl_i.pop) begin
      count_d = count_m1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // storage, written at the fill level
  always_ff @(posedge clk_i) begin
    if (ctl_i.push) begin
      entry_q[count_q[IDX_W-1:0]] <= ctl_i.digit;
    end
  end

  assign count_o = count_q;
  assign top_o   = entry_q[count_m1[IDX_W-1:0]];

endmodule

// ===== hdl/integer_to_base_digits.sv =====
// ----------------------------------------------------------------------------
// integer_to_base_digits
// Converts a signed integer into ASCII digits of base 2 to 16 (else base 10).
// ----------------------------------------------------------------------------
// Each digit takes one full pass of the bit-serial divider over VALUE_WIDTH
//   bits, then one character per cycle while the output is not stalled.
// One item at a time: the input stalls until its last character is loaded.
// Zero skips the divider. The divider loop and output stalls set the item time.
// Reset clears the control state and the stack count; stack entries are not
// cleared.
module integer_to_base_digits (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  ibd_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output ibd_pkg::out_item_t out_item_o
);
  import ibd_pkg::*;

  state_e           state_q, state_d;
  logic             neg_q, neg_d;
  logic [4:0]       base_q, base_d;
  logic             out_valid_q, out_valid_d;
  out_item_t        out_q, out_d;

  div_req_t         div_req;
  div_rsp_t         div_rsp;
  stk_ctl_t         stk_ctl;
  logic [CNT_W-1:0] stk_count;
  logic [3:0]       stk_top;

  logic                   in_accept;
  logic                   slot_free;
  logic                   value_zero;
  logic [VALUE_WIDTH-1:0] value_u;
  logic [VALUE_WIDTH-1:0] magnitude;
  logic [4:0]             in_base;
  logic                   div_finished;
  logic                   load;
  out_item_t              load_item;

  ibd_divider u_divider (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  ibd_stack u_stack (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (stk_ctl),
    .count_o (stk_count),
    .top_o   (stk_top)
  );

  // input decode
  always_comb begin
    value_u    = in_item_i.value;
    value_zero = value_u == '0;
    magnitude  = value_u[VALUE_WIDTH-1] ? (VALUE_WIDTH'(0) - value_u) : value_u;
    in_base    = (in_item_i.radix >= MIN_BASE && in_item_i.radix <= MAX_BASE)
               ? in_item_i.radix[4:0] : DEFAULT_BASE;
  end

  assign in_stall_o   = state_q != ST_IDLE;
  assign in_accept    = in_valid_i && !in_stall_o;
  assign slot_free    = !out_valid_q || !out_stall_i;
  assign div_finished = (div_rsp.quotient == '0) ||
                        (stk_count == CNT_W'(VALUE_WIDTH - 1));

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          state_d = value_zero ? ST_ZERO : ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        if (div_rsp.done && div_finished) begin
          state_d = neg_q ? ST_SIGN : ST_DIGITS;
        end
      end
      ST_SIGN: begin
        if (slot_free) begin
          state_d = ST_DIGITS;
        end
      end
      ST_DIGITS: begin
        if (slot_free && stk_count == CNT_W'(1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_ZERO: begin
        if (slot_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    div_req.start     = 1'b0;
    div_req.dividend  = div_rsp.quotient;
    div_req.divisor   = base_q;
    stk_ctl.push      = 1'b0;
    stk_ctl.pop       = 1'b0;
    stk_ctl.digit     = div_rsp.remainder;
    load              = 1'b0;
    load_item         = '{character: CHAR_ZERO, last: 1'b1};
    neg_d             = neg_q;
    base_d            = base_q;
    case (state_q)
      ST_IDLE: begin
        div_req.dividend = magnitude;
        div_req.divisor  = in_base;
        if (in_accept) begin
          neg_d  = value_u[VALUE_WIDTH-1];
          base_d = in_base;
          div_req.start = !value_zero;
        end
      end
      ST_DIVIDE: begin
        if (div_rsp.done) begin
          stk_ctl.push  = 1'b1;
          div_req.start = !div_finished;
        end
      end
      ST_SIGN: begin
        load      = slot_free;
        load_item = '{character: CHAR_MINUS, last: 1'b0};
      end
      ST_DIGITS: begin
        load        = slot_free;
        stk_ctl.pop = slot_free;
        load_item   = '{character: digit_char(stk_top), last: stk_count == CNT_W'(1)};
      end
      ST_ZERO: begin
        load = slot_free;
      end
      default: begin
        load = 1'b0;
      end
    endcase
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (load) begin
      out_valid_d = 1'b1;
      out_d       = load_item;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      neg_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      neg_q       <= neg_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    base_q <= base_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// ===== hdl/ibd_checker.sv =====
// ----------------------------------------------------------------------------
// ibd_checker
// Port-level checks for the integer to base digits block, bound to the top.
// ----------------------------------------------------------------------------
module ibd_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input ibd_pkg::in_item_t  in_item_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input ibd_pkg::out_item_t out_item_o
);
  import ibd_pkg::*;

  // a waiting input item holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_stall_o) |=> (in_valid_i && $stable(in_item_i)))
    else $error("stalled input item changed");

  // an accepted item keeps the block busy in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not stalled after an item was accepted");

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_item_o)))
    else $error("stalled result changed");

  // only sign, decimal digits and A to F appear
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      ((out_item_o.character >= CHAR_ZERO && out_item_o.character <= 8'h39) ||
       (out_item_o.character >= CHAR_ALPHA && out_item_o.character <= 8'h46) ||
       (out_item_o.character == CHAR_MINUS)))
    else $error("illegal character");

  // the sign is never the final character
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.character == CHAR_MINUS) |-> !out_item_o.last)
    else $error("sign marked last");

endmodule

bind integer_to_base_digits ibd_checker u_ibd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_item_i   (in_item_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);
